// ===== hdl/dchuff_pkg.sv =====
package dchuff_pkg;

   localparam int LEN_W   = 6;
   localparam int CODE_W  = 32;
   localparam int CNT_W   = 9;
   localparam int OUT_W   = 32;
   localparam int BCNT_W  = 3;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 2;
   localparam int PIX_W   = 8;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

   localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LEN     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_CODE = 2'd2;

   // symbol-indexed store controls
   typedef struct packed {
      logic rd;
      logic len_we;
      logic code_we;
   } sym_ctl_type;

   // length-indexed store controls
   typedef struct packed {
      logic cnt_rd;
      logic cnt_we;
      logic nc_rd;
      logic nc_we;
   } len_ctl_type;

   typedef struct packed {
      logic push;
      logic flush;
   } pack_ctl_type;

endpackage

// ===== hdl/dchuff_sym_mem.sv =====
module dchuff_sym_mem #(
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dchuff_pkg::sym_ctl_type          ctl,
   input  logic [$clog2(SYMBOL_COUNT)-1:0]  addr,
   input  logic [dchuff_pkg::LEN_W-1:0]     wr_len,
   input  logic [dchuff_pkg::CODE_W-1:0]    wr_code,
   output logic [dchuff_pkg::LEN_W-1:0]     rd_len,
   output logic [dchuff_pkg::CODE_W-1:0]    rd_code
);

   logic [dchuff_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
   logic [dchuff_pkg::CODE_W-1:0] code_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]       len_vld_ff;
   logic [dchuff_pkg::LEN_W-1:0]  rd_len_ff;
   logic [dchuff_pkg::CODE_W-1:0] rd_code_ff;

   // valid bits stand in for the all-zero reset of the length store
   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff <= '0;
      end else if (ctl.len_we) begin
         len_vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.len_we) begin
         len_mem[addr] <= wr_len;
      end
      if (ctl.code_we) begin
         code_mem[addr] <= wr_code;
      end
      if (ctl.rd) begin
         rd_len_ff  <= len_vld_ff[addr] ? len_mem[addr] : '0;
         rd_code_ff <= code_mem[addr];
      end
   end

   assign rd_len  = rd_len_ff;
   assign rd_code = rd_code_ff;

endmodule

// ===== hdl/dchuff_len_mem.sv =====
module dchuff_len_mem #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                               clock,
   input  dchuff_pkg::len_ctl_type            ctl,
   input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  addr,
   input  logic [dchuff_pkg::CNT_W-1:0]       cnt_wdata,
   input  logic [dchuff_pkg::CODE_W-1:0]      nc_wdata,
   output logic [dchuff_pkg::CNT_W-1:0]       cnt_rdata,
   output logic [dchuff_pkg::CODE_W-1:0]      nc_rdata
);

   localparam int DEPTH = MAX_CODE_LEN + 1;

   logic [dchuff_pkg::CNT_W-1:0]  cnt_mem [DEPTH];
   logic [dchuff_pkg::CODE_W-1:0] nc_mem  [DEPTH];
   logic [dchuff_pkg::CNT_W-1:0]  cnt_rd_ff;
   logic [dchuff_pkg::CODE_W-1:0] nc_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.cnt_we) begin
         cnt_mem[addr] <= cnt_wdata;
      end
      if (ctl.cnt_rd) begin
         cnt_rd_ff <= cnt_mem[addr];
      end
      if (ctl.nc_we) begin
         nc_mem[addr] <= nc_wdata;
      end
      if (ctl.nc_rd) begin
         nc_rd_ff <= nc_mem[addr];
      end
   end

   assign cnt_rdata = cnt_rd_ff;
   assign nc_rdata  = nc_rd_ff;

endmodule

// ===== hdl/dchuff_packer.sv =====
module dchuff_packer (
   input  logic                            clock,
   input  logic                            reset,
   input  dchuff_pkg::pack_ctl_type        ctl,
   input  logic [dchuff_pkg::LEN_W-1:0]    len,
   input  logic [dchuff_pkg::CODE_W-1:0]   code,
   output logic [dchuff_pkg::OUT_W-1:0]    packed_bytes,
   output logic [dchuff_pkg::BCNT_W-1:0]   byte_count
);

   logic [6:0]  acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [39:0] mask;
   logic [39:0] wide;
   logic [39:0] shifted;
   logic [5:0]  total;
   logic [2:0]  rem;
   logic [14:0] pad;

   always_comb begin
      mask    = (40'd1 << len) - 40'd1;
      wide    = ({33'd0, acc_ff} << len) | ({8'd0, code} & mask);
      total   = {3'd0, pend_ff} + len;
      rem     = total[2:0];
      shifted = wide >> rem;
      pad     = {8'd0, acc_ff} << (4'd8 - {1'b0, pend_ff});
      acc_in  = acc_ff;
      pend_in = pend_ff;
      packed_bytes = '0;
      byte_count   = '0;
      if (ctl.flush) begin
         packed_bytes = {24'd0, pad[7:0]};
         byte_count   = (pend_ff != 3'd0) ? 3'd1 : 3'd0;
         acc_in  = '0;
         pend_in = '0;
      end else if (ctl.push) begin
         packed_bytes = shifted[31:0];
         byte_count   = total[5:3];
         acc_in  = wide[6:0] & ((7'd1 << rem) - 7'd1);
         pend_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== hdl/delta_canonical_huffman_encoder.sv =====
// channel  dir  handshake             fields
// req      in   req_valid/req_stall   kind, symbol, code_length, pixel_value, row_start
// rsp      out  rsp_valid/rsp_stall   packed_bytes, byte_count, stream_end, error_code
//
// Load, pixel and flush items are accepted in IDLE, which writes (load) or reads
// (pixel) the symbol store, then EXEC forms the result into the output register.
// A build item walks the stores: CLR clears the count of every length,
// CNT_A/B/C count the symbols of each length, NC_A/B form the first codes,
// AS_A/B/C give each coded symbol its code, then EXEC forms the result.
// Reset is synchronous; length entries read as zero until loaded, no sweep.
// A stalled result holds in the output register; the next item waits only
// if its result would need that register while it is still full.
module delta_canonical_huffman_encoder #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_kind,
   input  logic [7:0]   req_symbol,
   input  logic [7:0]   req_code_length,
   input  logic [7:0]   req_pixel_value,
   input  logic         req_row_start,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_packed_bytes,
   output logic [2:0]   rsp_byte_count,
   output logic         rsp_stream_end,
   output logic [1:0]   rsp_error_code
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   localparam int CL_W  = $clog2(MAX_CODE_LEN + 1);
   localparam logic [IDX_W-1:0] LAST_SYM = IDX_W'(SYMBOL_COUNT - 1);
   localparam logic [CL_W-1:0]  LAST_LEN = CL_W'(MAX_CODE_LEN);
   localparam logic [8:0]       SYM_LIM  = 9'(SYMBOL_COUNT);
   localparam logic [7:0]       LEN_LIM  = 8'(MAX_CODE_LEN);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_EXEC  = 11'b000_0000_0010,
      ST_CLR   = 11'b000_0000_0100,
      ST_CNT_A = 11'b000_0000_1000,
      ST_CNT_B = 11'b000_0001_0000,
      ST_CNT_C = 11'b000_0010_0000,
      ST_NC_A  = 11'b000_0100_0000,
      ST_NC_B  = 11'b000_1000_0000,
      ST_AS_A  = 11'b001_0000_0000,
      ST_AS_B  = 11'b010_0000_0000,
      ST_AS_C  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]  sym_ff, sym_in;
   logic [CL_W-1:0]   len_ff, len_in;
   logic [31:0]       code_ff, code_in;
   logic [1:0]        kind_ff, kind_in;
   logic [1:0]        err_ff, err_in;
   logic              rok_ff, rok_in;
   logic [7:0]        prev_ff, prev_in;
   logic              rv_ff, rv_in;
   logic [31:0]       rb_ff, rb_in;
   logic [2:0]        rc_ff, rc_in;
   logic              re_ff, re_in;
   logic [1:0]        rerr_ff, rerr_in;

   dchuff_pkg::sym_ctl_type  sctl;
   dchuff_pkg::len_ctl_type  lctl;
   dchuff_pkg::pack_ctl_type pctl;
   logic [IDX_W-1:0]  saddr;
   logic [5:0]        swlen;
   logic [5:0]        rd_len;
   logic [31:0]       rd_code;
   logic [CL_W-1:0]   laddr;
   logic [8:0]        cnt_wdata, cnt_rdata;
   logic [31:0]       nc_wdata, nc_rdata;
   logic [31:0]       pk_bytes;
   logic [2:0]        pk_count;
   logic [7:0]        resid;
   logic              accept, out_free, last_sym;

   dchuff_sym_mem #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_sym (
      .clock(clock), .reset(reset), .ctl(sctl), .addr(saddr),
      .wr_len(swlen), .wr_code(nc_rdata), .rd_len(rd_len), .rd_code(rd_code)
   );

   dchuff_len_mem #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_len (
      .clock(clock), .ctl(lctl), .addr(laddr), .cnt_wdata(cnt_wdata),
      .nc_wdata(nc_wdata), .cnt_rdata(cnt_rdata), .nc_rdata(nc_rdata)
   );

   dchuff_packer u_pack (
      .clock(clock), .reset(reset), .ctl(pctl), .len(rd_len), .code(rd_code),
      .packed_bytes(pk_bytes), .byte_count(pk_count)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rv_ff || !rsp_stall;
   assign resid     = req_row_start ? req_pixel_value : (req_pixel_value - prev_ff);
   assign last_sym  = (sym_ff == LAST_SYM);

   always_comb begin
      state_in = state_ff;
      sym_in   = sym_ff;
      len_in   = len_ff;
      code_in  = code_ff;
      kind_in  = kind_ff;
      err_in   = err_ff;
      rok_in   = rok_ff;
      prev_in  = prev_ff;
      rv_in    = rv_ff && rsp_stall;
      rb_in    = rb_ff;
      rc_in    = rc_ff;
      re_in    = re_ff;
      rerr_in  = rerr_ff;
      sctl     = '0;
      lctl     = '0;
      pctl     = '0;
      saddr    = sym_ff;
      swlen    = '0;
      laddr    = len_ff;
      cnt_wdata = '0;
      nc_wdata  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               err_in   = dchuff_pkg::ERR_OK;
               state_in = ST_EXEC;
               case (req_kind)
                  dchuff_pkg::KIND_LOAD: begin
                     saddr = req_symbol[IDX_W-1:0];
                     if ({1'b0, req_symbol} < SYM_LIM) begin
                        sctl.len_we = 1'b1;
                        if (req_code_length > LEN_LIM) begin
                           err_in = dchuff_pkg::ERR_LEN;
                        end else begin
                           swlen = req_code_length[5:0];
                        end
                     end
                  end
                  dchuff_pkg::KIND_BUILD: begin
                     len_in   = '0;
                     state_in = ST_CLR;
                  end
                  dchuff_pkg::KIND_PIXEL: begin
                     saddr   = resid[IDX_W-1:0];
                     rok_in  = ({1'b0, resid} < SYM_LIM);
                     sctl.rd = 1'b1;
                     prev_in = req_pixel_value;
                  end
                  default: ;
               endcase
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rb_in    = '0;
               rc_in    = '0;
               re_in    = 1'b0;
               rerr_in  = err_ff;
               state_in = ST_IDLE;
               case (kind_ff)
                  dchuff_pkg::KIND_FLUSH: begin
                     pctl.flush = 1'b1;
                     rb_in = pk_bytes;
                     rc_in = pk_count;
                     re_in = 1'b1;
                  end
                  dchuff_pkg::KIND_PIXEL: begin
                     if (rok_ff && rd_len != 6'd0) begin
                        pctl.push = 1'b1;
                        rb_in = pk_bytes;
                        rc_in = pk_count;
                     end else begin
                        rerr_in = dchuff_pkg::ERR_NO_CODE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLR: begin
            lctl.cnt_we = 1'b1;
            if (len_ff == LAST_LEN) begin
               sym_in   = '0;
               state_in = ST_CNT_A;
            end else begin
               len_in = len_ff + 1'b1;
            end
         end
         ST_CNT_A: begin
            sctl.rd  = 1'b1;
            state_in = ST_CNT_B;
         end
         ST_CNT_B: begin
            laddr = rd_len[CL_W-1:0];
            if (rd_len != 6'd0) begin
               lctl.cnt_rd = 1'b1;
               state_in    = ST_CNT_C;
            end else if (last_sym) begin
               len_in   = CL_W'(1);
               code_in  = '0;
               state_in = ST_NC_A;
            end else begin
               sym_in   = sym_ff + 1'b1;
               state_in = ST_CNT_A;
            end
         end
         ST_CNT_C: begin
            laddr       = rd_len[CL_W-1:0];
            lctl.cnt_we = 1'b1;
            cnt_wdata   = cnt_rdata + 9'd1;
            if (last_sym) begin
               len_in   = CL_W'(1);
               code_in  = '0;
               state_in = ST_NC_A;
            end else begin
               sym_in   = sym_ff + 1'b1;
               state_in = ST_CNT_A;
            end
         end
         ST_NC_A: begin
            laddr       = len_ff - 1'b1;
            lctl.cnt_rd = 1'b1;
            state_in    = ST_NC_B;
         end
         ST_NC_B: begin
            // first code of this length from the count one shorter
            code_in    = (code_ff + {23'd0, cnt_rdata}) << 1;
            nc_wdata   = code_in;
            lctl.nc_we = 1'b1;
            if (len_ff == LAST_LEN) begin
               sym_in   = '0;
               state_in = ST_AS_A;
            end else begin
               len_in   = len_ff + 1'b1;
               state_in = ST_NC_A;
            end
         end
         ST_AS_A: begin
            sctl.rd  = 1'b1;
            state_in = ST_AS_B;
         end
         ST_AS_B: begin
            laddr = rd_len[CL_W-1:0];
            if (rd_len != 6'd0) begin
               lctl.nc_rd = 1'b1;
               state_in   = ST_AS_C;
            end else if (last_sym) begin
               state_in = ST_EXEC;
            end else begin
               sym_in   = sym_ff + 1'b1;
               state_in = ST_AS_A;
            end
         end
         ST_AS_C: begin
            laddr        = rd_len[CL_W-1:0];
            sctl.code_we = 1'b1;
            lctl.nc_we   = 1'b1;
            nc_wdata     = nc_rdata + 32'd1;
            if (last_sym) begin
               state_in = ST_EXEC;
            end else begin
               sym_in   = sym_ff + 1'b1;
               state_in = ST_AS_A;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      len_ff  <= len_in;
      code_ff <= code_in;
      kind_ff <= kind_in;
      err_ff  <= err_in;
      rok_ff  <= rok_in;
      rb_ff   <= rb_in;
      rc_ff   <= rc_in;
      re_ff   <= re_in;
      rerr_ff <= rerr_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_packed_bytes = rb_ff;
   assign rsp_byte_count   = rc_ff;
   assign rsp_stream_end   = re_ff;
   assign rsp_error_code   = rerr_ff;

endmodule

// ===== hdl/dchuff_checker.sv =====
module dchuff_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_packed_bytes,
   input logic [2:0]  rsp_byte_count,
   input logic        rsp_stream_end,
   input logic [1:0]  rsp_error_code
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_bytes))
      else $error("stalled item changed");

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 3'd4)
      else $error("byte count above four");

   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |->
         rsp_error_code == 2'd0 && rsp_byte_count <= 3'd1)
      else $error("flush item malformed");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != 2'd0 |->
         rsp_byte_count == 3'd0 && rsp_packed_bytes == 32'd0)
      else $error("error item carries bytes");

endmodule

bind delta_canonical_huffman_encoder dchuff_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_packed_bytes(rsp_packed_bytes), .rsp_byte_count(rsp_byte_count),
   .rsp_stream_end(rsp_stream_end), .rsp_error_code(rsp_error_code)
);

// ===== tb/tb_delta_canonical_huffman_encoder.sv =====
`timescale 1ns / 1ps

module tb_delta_canonical_huffman_encoder;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [7:0]  req_symbol;
   logic [7:0]  req_code_length;
   logic [7:0]  req_pixel_value;
   logic        req_row_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_packed_bytes;
   logic [2:0]  rsp_byte_count;
   logic        rsp_stream_end;
   logic [1:0]  rsp_error_code;

   delta_canonical_huffman_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_symbol       (req_symbol),
      .req_code_length  (req_code_length),
      .req_pixel_value  (req_pixel_value),
      .req_row_start    (req_row_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_bytes (rsp_packed_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_stream_end   (rsp_stream_end),
      .rsp_error_code   (rsp_error_code)
   );

   // one result item as the encoder should produce it
   typedef struct {
      logic [31:0] packed_bytes;
      logic [2:0]  byte_count;
      logic        stream_end;
      logic [1:0]  error_code;
   } coded_out_type;

   coded_out_type pending_results[$];

   // encoder state as predicted
   logic [5:0]  enc_len[256];
   logic [31:0] enc_code[256];
   bit          code_known[256];   // code written by some build
   logic [8:0]  len_count[33];
   logic [31:0] first_code[33];
   logic [6:0]  acc_bits;
   logic [2:0]  acc_fill;
   logic [7:0]  last_pixel;

   int unsigned fail_count;
   bit          quiet;             // no random idling while set
   bit          hold_request;      // asks the receiver for a long hold-off

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("tb_delta_canonical_huffman_encoder: FAIL");
      $finish;
   end

   // canonical code assignment, as a build item does it
   task automatic assign_codes();
      logic [31:0] code;
      for (int l = 0; l <= 32; l++) len_count[l] = '0;
      for (int s = 0; s < 256; s++)
         if (enc_len[s] != 0) len_count[enc_len[s]] = len_count[enc_len[s]] + 9'd1;
      code = '0;
      first_code[0] = '0;
      for (int l = 1; l <= 32; l++) begin
         code = (code + 32'(len_count[l-1])) << 1;
         first_code[l] = code;
      end
      for (int s = 0; s < 256; s++)
         if (enc_len[s] != 0) begin
            enc_code[s]   = first_code[enc_len[s]];
            code_known[s] = 1'b1;
            first_code[enc_len[s]] = first_code[enc_len[s]] + 32'd1;
         end
   endtask

   // works out the result of one accepted item and advances the state
   task automatic encode_item(input logic [1:0] kind, input logic [7:0] sym,
                              input logic [7:0] clen, input logic [7:0] pix,
                              input logic rs);
      coded_out_type r;
      logic [7:0]  resid;
      int unsigned len, total, rem, cnt;
      logic [63:0] acc;
      r = '{packed_bytes: '0, byte_count: '0, stream_end: 1'b0,
            error_code: dchuff_pkg::ERR_OK};
      case (kind)
         dchuff_pkg::KIND_LOAD: begin
            if (clen > 32) begin
               enc_len[sym] = '0;
               r.error_code = dchuff_pkg::ERR_LEN;
            end else begin
               enc_len[sym] = clen[5:0];
            end
         end
         dchuff_pkg::KIND_BUILD: assign_codes();
         dchuff_pkg::KIND_PIXEL: begin
            resid = rs ? pix : pix - last_pixel;
            last_pixel = pix;
            len = enc_len[resid];
            if (len == 0) begin
               r.error_code = dchuff_pkg::ERR_NO_CODE;
            end else begin
               acc   = (64'(acc_bits) << len) | (64'(enc_code[resid]) & ((64'd1 << len) - 1));
               total = acc_fill + len;
               rem   = total & 7;
               cnt   = total >> 3;
               r.packed_bytes = 32'((acc >> rem) & ((64'd1 << (cnt * 8)) - 1));
               r.byte_count   = 3'(cnt);
               acc_bits = 7'(acc & ((64'd1 << rem) - 1));
               acc_fill = 3'(rem);
            end
         end
         default: begin
            if (acc_fill != 0) begin
               r.packed_bytes = {24'd0, {1'b0, acc_bits} << (4'd8 - {1'b0, acc_fill})};
               r.byte_count   = 3'd1;
            end
            acc_bits = '0;
            acc_fill = '0;
            r.stream_end = 1'b1;
         end
      endcase
      pending_results = {pending_results, r};
   endtask

   // offers one item and waits until the encoder takes it
   task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                            input logic [7:0] clen, input logic [7:0] pix,
                            input logic rs);
      if (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_symbol      <= sym;
      req_code_length <= clen;
      req_pixel_value <= pix;
      req_row_start   <= rs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_item(kind, sym, clen, pix, rs);
   endtask

   task automatic send_load(input logic [7:0] sym, input logic [7:0] clen);
      send_item(dchuff_pkg::KIND_LOAD, sym, clen, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_build();
      send_item(dchuff_pkg::KIND_BUILD, 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   task automatic send_flush();
      send_item(dchuff_pkg::KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   task automatic send_pixel(input logic [7:0] pix, input logic rs);
      send_item(dchuff_pkg::KIND_PIXEL, 8'($urandom), 8'($urandom), pix, rs);
   endtask

   // a residual with a length must have a code from some build
   function automatic bit pixel_is_legal(input logic [7:0] pix, input logic rs);
      logic [7:0] resid;
      resid = rs ? pix : pix - last_pixel;
      return enc_len[resid] == 0 || code_known[resid];
   endfunction

   // pixel aimed at a coded residual most of the time, noise otherwise
   task automatic send_random_pixel(input bit aim);
      logic [7:0] s, pix;
      logic       rs;
      bit         found;
      found = 1'b0;
      if (aim)
         for (int t = 0; t < 40 && !found; t++) begin
            s = 8'($urandom);
            if (enc_len[s] != 0 && code_known[s]) found = 1'b1;
         end
      if (found) begin
         rs  = ($urandom_range(7) == 0);
         pix = rs ? s : last_pixel + s;
      end else begin
         for (int t = 0; t < 100 && !found; t++) begin
            pix = 8'($urandom);
            rs  = 1'($urandom);
            found = pixel_is_legal(pix, rs);
         end
         if (!found) begin
            // lengths loaded but never built: build first
            send_build();
            pix = 8'($urandom);
            rs  = 1'($urandom);
         end
      end
      send_pixel(pix, rs);
   endtask

   // stops offering, then waits for every expected item
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // flush with empty packer, lengths at and past the limit, no-code pixels
   task automatic test_limits();
      send_flush();
      send_pixel(8'd0, 1'b1);          // residual has no code yet
      send_load(8'd7, 8'd33);
      send_load(8'd8, 8'd255);
      send_load(8'd9, 8'd32);
      send_load(8'd0, 8'd1);
      send_load(8'd1, 8'd3);
      send_load(8'd255, 8'd3);
      send_load(8'd128, 8'd7);
      send_load(8'd7, 8'd0);
      send_build();
   endtask

   // pixels through the packer, row starts, wrap of the residual
   task automatic test_pixels();
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd0, 1'b0);          // residual 255
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd9, 1'b1);          // 32-bit code
      send_pixel(8'd18, 1'b0);
      send_pixel(8'd200, 1'b0);        // no code
      send_pixel(8'd255, 1'b1);
      send_flush();                    // pads a partial byte
   endtask

   // more codes than the lengths allow: codes wrap
   task automatic test_oversubscribed();
      send_load(8'd2, 8'd1);
      send_load(8'd3, 8'd1);
      send_load(8'd4, 8'd1);
      send_build();
      for (int i = 0; i < 6; i++) send_pixel(8'(i + 1), 1'b1);
      send_flush();
   endtask

   // rounds of length updates, build, then a burst of pixels
   task automatic test_random();
      int unsigned sent, r;
      logic [7:0]  clen;
      sent = 0;
      for (int s = 0; s < 256; s++) begin
         send_load(8'(s), 8'($urandom_range(12, 1)));
         sent++;
      end
      while (sent < 1450) begin
         quiet = (sent > 600 && sent < 850);
         for (int i = $urandom_range(25, 5); i > 0; i--) begin
            r = $urandom_range(99);
            if (r < 70)      clen = 8'($urandom_range(10, 1));
            else if (r < 85) clen = 8'd0;
            else if (r < 95) clen = 8'($urandom_range(32, 11));
            else             clen = 8'($urandom_range(255, 33));
            send_load(8'($urandom), clen);
            sent++;
         end
         if ($urandom_range(9) != 0) begin
            send_build();
            sent++;
         end
         for (int i = $urandom_range(120, 40); i > 0; i--) begin
            if ($urandom_range(39) == 0) send_flush();
            else send_random_pixel($urandom_range(99) < 85);
            sent++;
         end
      end
      quiet = 1'b0;
      send_flush();
   endtask

   // receiver holds off for long while pixels keep coming
   task automatic test_backpressure();
      wait_drained();
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) send_random_pixel(1'b1);
      send_flush();
   endtask

   // receiver: random stalls, and a long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 7);
         end
      end
   end

   // compares each result item with the oldest expectation
   always @(posedge clock) begin
      coded_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result item %h/%0d/%0d/%0d", $time,
                     rsp_packed_bytes, rsp_byte_count, rsp_stream_end, rsp_error_code);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_packed_bytes !== e.packed_bytes) begin
               $display("%0t: packed_bytes expected %h actual %h", $time,
                        e.packed_bytes, rsp_packed_bytes);
               fail_count++;
            end
            if (rsp_byte_count !== e.byte_count) begin
               $display("%0t: byte_count expected %0d actual %0d", $time,
                        e.byte_count, rsp_byte_count);
               fail_count++;
            end
            if (rsp_stream_end !== e.stream_end) begin
               $display("%0t: stream_end expected %0d actual %0d", $time,
                        e.stream_end, rsp_stream_end);
               fail_count++;
            end
            if (rsp_error_code !== e.error_code) begin
               $display("%0t: error_code expected %0d actual %0d", $time,
                        e.error_code, rsp_error_code);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = dchuff_pkg::KIND_LOAD;
      req_symbol      = '0;
      req_code_length = '0;
      req_pixel_value = '0;
      req_row_start   = 1'b0;
      rsp_stall       = 1'b0;
      fail_count      = 0;
      quiet           = 1'b0;
      hold_request    = 1'b0;
      for (int s = 0; s < 256; s++) begin
         enc_len[s]    = '0;
         enc_code[s]   = '0;
         code_known[s] = 1'b0;
      end
      for (int l = 0; l <= 32; l++) begin
         len_count[l]  = '0;
         first_code[l] = '0;
      end
      acc_bits   = '0;
      acc_fill   = '0;
      last_pixel = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_limits();
      test_pixels();
      test_oversubscribed();
      test_random();
      test_backpressure();

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("tb_delta_canonical_huffman_encoder: PASS");
      else
         $display("tb_delta_canonical_huffman_encoder: FAIL");
      $finish;
   end

endmodule
